>>> rtl/sci_pkg.sv
// Shared types for the segment/circle intersection pipeline.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sci_pkg;

  typedef struct packed {
    logic en;
  } sci_pipe_t;

endpackage
`default_nettype wire

>>> rtl/segment_circle_intersection_core.sv
// Segment/circle intersection top level: quadratic setup, square root and
// two dividers in one stall-together pipeline. Depends on sci_pkg, sci_isqrt, sci_div.
// Throughput is one item per cycle; the whole pipeline holds when the
// output item is not taken. The isqrt stages (one per root bit) set the depth.
// Reset clears all valid bits; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module segment_circle_intersection_core #(
  parameter int COORD_BITS  = 12,
  parameter int T_FRAC_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [COORD_BITS-1:0] start_x,
  input  wire logic signed [COORD_BITS-1:0] start_y,
  input  wire logic signed [COORD_BITS-1:0] end_x,
  input  wire logic signed [COORD_BITS-1:0] end_y,
  input  wire logic signed [COORD_BITS-1:0] center_x,
  input  wire logic signed [COORD_BITS-1:0] center_y,
  input  wire logic        [COORD_BITS-2:0] circle_radius,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              hit,
  output logic             [T_FRAC_BITS:0]  t_enter,
  output logic             [T_FRAC_BITS:0]  t_exit
);
  localparam int D   = COORD_BITS + 1;
  localparam int AW  = 2 * D;
  localparam int BW  = 2 * D + 1;
  localparam int PW  = 2 * BW;
  localparam int SW  = 4 * D;
  localparam int RW  = 2 * D;
  localparam int NW  = BW + 1;
  localparam int RRW = 2 * (COORD_BITS - 1);
  localparam int LAT = RW + T_FRAC_BITS + 7;

  sci_pkg::sci_pipe_t ctl;
  logic [LAT-1:0] vld;

  always_comb begin
    ctl.en   = !out_valid || out_ready;
    in_ready = ctl.en;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ctl.en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end
  assign out_valid = vld[LAT-1];

  logic signed [D-1:0]   dx, dy, fx, fy;
  logic        [COORD_BITS-2:0] rad;
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      dx  <= D'(end_x) - D'(start_x);
      dy  <= D'(end_y) - D'(start_y);
      fx  <= D'(start_x) - D'(center_x);
      fy  <= D'(start_y) - D'(center_y);
      rad <= circle_radius;
    end
  end

  logic signed [2*D-1:0] p_dxx, p_dyy, p_fdx, p_fdy, p_fxx, p_fyy;
  logic        [RRW-1:0] p_rr;
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      p_dxx <= dx * dx;
      p_dyy <= dy * dy;
      p_fdx <= fx * dx;
      p_fdy <= fy * dy;
      p_fxx <= fx * fx;
      p_fyy <= fy * fy;
      p_rr  <= rad * rad;
    end
  end

  logic        [AW-1:0] qa;
  logic signed [BW-1:0] qb, qc;
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      qa <= AW'(p_dxx) + AW'(p_dyy);
      qb <= BW'(p_fdx) + BW'(p_fdy);
      qc <= BW'(p_fxx) + BW'(p_fyy) - $signed(BW'({1'b0, p_rr}));
    end
  end

  logic signed [PW-1:0] m_bb, m_ac;
  logic        [AW-1:0] m_a;
  logic signed [BW-1:0] m_b, m_c;
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      m_bb <= qb * qb;
      m_ac <= $signed({1'b0, qa}) * qc;
      m_a  <= qa;
      m_b  <= qb;
      m_c  <= qc;
    end
  end

  logic signed [PW-1:0]   disc;
  logic                   e_hit;
  logic        [AW-1:0]   e_a;
  logic signed [BW-1:0]   e_b;
  logic signed [BW+1:0]   sum_ab, sum_abc;
  logic signed [PW-1:0]   disc_next;
  logic                   hit_next;
  always_comb begin
    disc_next = m_bb - m_ac;
    sum_ab    = $signed({2'b00, m_a}) + (BW+2)'(m_b);
    sum_abc   = sum_ab + (BW+2)'(m_b) + (BW+2)'(m_c);
    hit_next  = (m_a != '0) && !disc_next[PW-1]
             && !(m_b > 0 && m_c > 0)
             && !(sum_ab < 0 && sum_abc > 0);
  end
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      disc  <= disc_next;
      e_hit <= hit_next;
      e_a   <= m_a;
      e_b   <= m_b;
    end
  end

  logic [SW-1:0] sq_in;
  logic [RW-1:0] sq_root;
  assign sq_in = (disc[PW-1] || !e_hit) ? '0 : disc[SW-1:0];

  sci_isqrt #(.IW(SW)) u_sqrt (
    .clk (clk),
    .ctl (ctl),
    .din (sq_in),
    .root(sq_root)
  );

  logic                 sq_hit [RW+1];
  logic        [AW-1:0] sq_a   [RW+1];
  logic signed [BW-1:0] sq_b   [RW+1];
  always_comb begin
    sq_hit[0] = e_hit;
    sq_a[0]   = e_a;
    sq_b[0]   = e_b;
  end
  for (genvar i = 0; i < RW; i++) begin : g_sq_side
    always_ff @(posedge clk) begin
      if (ctl.en) begin
        sq_hit[i+1] <= sq_hit[i];
        sq_a[i+1]   <= sq_a[i];
        sq_b[i+1]   <= sq_b[i];
      end
    end
  end

  logic signed [NW-1:0] n_lo, n_hi, a_ext;
  always_comb begin
    a_ext = $signed(NW'({1'b0, sq_a[RW]}));
    n_lo  = -NW'(sq_b[RW]) - $signed(NW'({1'b0, sq_root}));
    n_hi  = -NW'(sq_b[RW]) + $signed(NW'({1'b0, sq_root}));
  end

  logic        nv_hit, lo_zero, lo_one, hi_zero, hi_one;
  logic [AW-1:0] nv_lo, nv_hi, nv_a;
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      nv_hit  <= sq_hit[RW];
      lo_zero <= n_lo <= 0;
      lo_one  <= n_lo >= a_ext;
      hi_zero <= n_hi <= 0;
      hi_one  <= n_hi >= a_ext;
      nv_lo   <= (n_lo > 0 && n_lo < a_ext) ? n_lo[AW-1:0] : '0;
      nv_hi   <= (n_hi > 0 && n_hi < a_ext) ? n_hi[AW-1:0] : '0;
      nv_a    <= (sq_a[RW] == '0) ? AW'(1) : sq_a[RW];
    end
  end

  logic [T_FRAC_BITS-1:0] q_lo, q_hi;

  sci_div #(.AW(AW), .QW(T_FRAC_BITS)) u_div_lo (
    .clk(clk), .ctl(ctl), .num(nv_lo), .den(nv_a), .quo(q_lo)
  );
  sci_div #(.AW(AW), .QW(T_FRAC_BITS)) u_div_hi (
    .clk(clk), .ctl(ctl), .num(nv_hi), .den(nv_a), .quo(q_hi)
  );

  logic [3:0] dv_flags [T_FRAC_BITS+1];
  logic       dv_hit   [T_FRAC_BITS+1];
  always_comb begin
    dv_flags[0] = {lo_zero, lo_one, hi_zero, hi_one};
    dv_hit[0]   = nv_hit;
  end
  for (genvar i = 0; i < T_FRAC_BITS; i++) begin : g_dv_side
    always_ff @(posedge clk) begin
      if (ctl.en) begin
        dv_flags[i+1] <= dv_flags[i];
        dv_hit[i+1]   <= dv_hit[i];
      end
    end
  end

  localparam logic [T_FRAC_BITS:0] T_ONE = (T_FRAC_BITS+1)'(1) << T_FRAC_BITS;

  logic [3:0] fl;
  assign fl = dv_flags[T_FRAC_BITS];

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      hit <= dv_hit[T_FRAC_BITS];
      if (!dv_hit[T_FRAC_BITS]) begin
        t_enter <= '0;
        t_exit  <= '0;
      end else begin
        t_enter <= fl[3] ? '0 : fl[2] ? T_ONE : {1'b0, q_lo};
        t_exit  <= fl[1] ? '0 : fl[0] ? T_ONE : {1'b0, q_hi};
      end
    end
  end
endmodule
`default_nettype wire

>>> rtl/sci_isqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Depends on sci_pkg for the pipeline control struct.
`timescale 1ns / 1ps
`default_nettype none
module sci_isqrt #(
  parameter int IW = 52
) (
  input  wire logic                clk,
  input  wire sci_pkg::sci_pipe_t  ctl,
  input  wire logic [IW-1:0]       din,
  output logic      [IW/2-1:0]     root
);
  localparam int RW = IW / 2;

  logic [RW:0]   rem_q  [RW+1];
  logic [RW-1:0] root_q [RW+1];
  logic [IW-1:0] x_q    [RW+1];

  always_comb begin
    rem_q[0]  = '0;
    root_q[0] = '0;
    x_q[0]    = din;
  end

  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic [RW+1:0] r2;
    logic [RW+1:0] trial;
    logic [RW+1:0] diff;
    logic          ge;
    always_comb begin
      r2    = {rem_q[i][RW-1:0], x_q[i][IW-1:IW-2]};
      trial = {root_q[i], 2'b01};
      ge    = r2 >= trial;
      diff  = r2 - trial;
    end
    always_ff @(posedge clk) begin
      if (ctl.en) begin
        rem_q[i+1]  <= ge ? diff[RW:0] : r2[RW:0];
        root_q[i+1] <= {root_q[i][RW-2:0], ge};
        x_q[i+1]    <= {x_q[i][IW-3:0], 2'b00};
      end
    end
  end

  assign root = root_q[RW];
endmodule
`default_nettype wire

>>> rtl/sci_div.sv
// Pipelined restoring divider for a numerator below the divisor,
// one quotient bit per register stage. Depends on sci_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sci_div #(
  parameter int AW = 26,
  parameter int QW = 16
) (
  input  wire logic               clk,
  input  wire sci_pkg::sci_pipe_t ctl,
  input  wire logic [AW-1:0]      num,
  input  wire logic [AW-1:0]      den,
  output logic      [QW-1:0]      quo
);
  logic [AW-1:0] rem_q [QW+1];
  logic [AW-1:0] den_q [QW+1];
  logic [QW-1:0] quo_q [QW+1];

  always_comb begin
    rem_q[0] = num;
    den_q[0] = den;
    quo_q[0] = '0;
  end

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [AW:0] r2;
    logic [AW:0] diff;
    logic        ge;
    always_comb begin
      r2   = {rem_q[i], 1'b0};
      ge   = r2 >= {1'b0, den_q[i]};
      diff = r2 - {1'b0, den_q[i]};
    end
    always_ff @(posedge clk) begin
      if (ctl.en) begin
        rem_q[i+1] <= ge ? diff[AW-1:0] : r2[AW-1:0];
        den_q[i+1] <= den_q[i];
        quo_q[i+1] <= {quo_q[i][QW-2:0], ge};
      end
    end
  end

  assign quo = quo_q[QW];
endmodule
`default_nettype wire
